[sv/text_console_row_ring_defines.svh]
// Assertion macros used by the port-level checker.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef TEXT_CONSOLE_ROW_RING_DEFINES_SVH
`define TEXT_CONSOLE_ROW_RING_DEFINES_SVH

// Concurrent check that is switched off while reset is held.
`define TCRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent check that also holds while reset is held.
`define TCRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/tcrr_pkg.sv]
// Shared types and constants for the text console row ring.
// Depends on nothing; used by the top level, both checkers and the testbench.
`default_nettype none

package tcrr_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } tcrr_state_e;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] COLOR_BLANK = 8'h00;
  localparam logic [7:0] COLOR_RESET = 8'h07;

endpackage

`default_nettype wire

[sv/tcrr_cell_ram.sv]
// Cell store: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module tcrr_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int DW    = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/tcrr_len_ram.sv]
// Row length store: per-row index of the first zero cell, with a valid bit
// per row so that unwritten rows read as zero. Depends on nothing.
`default_nettype none

module tcrr_len_ram #(
  parameter int ENTRIES = 25,
  parameter int DW      = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       we_i,
  input  wire logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  wire logic [DW-1:0]              wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic      [DW-1:0]              rdata_o
);

  logic [DW-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [DW-1:0]      rdata_q;
  logic               rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // an unwritten row has no characters yet
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

[sv/text_console_row_ring.sv]
// Text console over a ring of rows: cell store and row length store plus
// the cursor, scroll and read-out control. Depends on tcrr_pkg,
// tcrr_cell_ram and tcrr_len_ram.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one word per item:
//    operation_i selects put character or read cell. A put returns
//    nothing; a read returns one word on the output channel.
//  - Output channel (out_valid_o / out_stall_i) carries cell_char_o and
//    cell_color_o from an output register.
//  - cfg_we_i / cfg_wdata_i write the text colour; write it while idle.
//  - A put is accepted and, at that edge, edits the cursor, the bottom row
//    and the row length, writes the row length store and, for a character
//    other than backspace or newline, the cell store. A read reads both
//    stores at the accept edge into their registered read ports; the lookup
//    state then loads the result into the output register once it is free.
//  - While the output register is full and stalled, a finished read waits
//    in the lookup state and the input side stays stalled.
//  - Reset clears cursor, bottom row, colour (to 7) and the row length
//    valid bits at once; no clearing pass is run, because cells beyond a
//    row's recorded length are never shown.
`default_nettype none

module text_console_row_ring #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [4:0] screen_row_i,
  input  wire logic [6:0] screen_col_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] cell_char_o,
  output logic      [7:0] cell_color_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS + 1);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = (CW > 7) ? CW : 7;
  localparam int SRN   = 32;

  // screen row reduced modulo ROWS, worked out at elaboration
  logic [RW-1:0] row_mod [SRN];
  for (genvar g = 0; g < SRN; g++) begin : g_row_mod
    assign row_mod[g] = RW'(g % ROWS);
  end

  tcrr_pkg::tcrr_state_e state_q, state_d;

  logic [7:0]    text_color_q;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [RW-1:0] bottom_q, bottom_d;
  logic [CW-1:0] rowlen_q, rowlen_d;   // first zero cell of the bottom row
  logic [6:0]    scol_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [7:0]    out_color_q, out_color_d;

  logic accept, put_fire, read_fire, out_load;

  // put path
  logic          is_bs, is_nl, is_print, scroll;
  logic [CW-1:0] cur_bs, put_col, len_base, put_len, put_cursor;
  logic [RW-1:0] bottom_inc, put_row;

  // read path
  logic [RW:0]     row_sum;
  logic [RW-1:0]   ring_row;
  logic            col_in_range;
  logic [6:0]      rd_col;
  logic [AW-1:0]   cell_waddr, cell_raddr;
  logic [15:0]     cell_rdata;
  logic [CW-1:0]   len_rdata;
  logic            hit;

  assign accept    = in_valid_i && !in_stall_o;
  assign put_fire  = accept && (operation_i == tcrr_pkg::OP_PUT);
  assign read_fire = accept && (operation_i == tcrr_pkg::OP_READ);

  // Put: backspace first, then scroll on newline or a full row, then store.
  // The row length tracks the first zero cell, so the trailing zero cell
  // need not be written into the cell store.
  always_comb begin
    is_bs    = (char_code_i == tcrr_pkg::CHAR_BS);
    is_nl    = (char_code_i == tcrr_pkg::CHAR_NL);
    is_print = !is_bs && !is_nl;

    cur_bs = (is_bs && (cursor_q != '0)) ? cursor_q - 1'b1 : cursor_q;
    scroll = is_nl || (cur_bs == CW'(COLS));

    bottom_inc = (bottom_q == RW'(ROWS - 1)) ? '0 : bottom_q + 1'b1;
    put_row    = scroll ? bottom_inc : bottom_q;
    put_col    = scroll ? '0 : cur_bs;
    len_base   = scroll ? '0 : rowlen_q;

    if (is_bs) begin
      // zero written at the new cursor
      put_len = (cur_bs < len_base) ? cur_bs : len_base;
    end else if (is_print && (put_col == len_base) &&
                 (char_code_i != tcrr_pkg::CHAR_NUL)) begin
      // extend the row over the new character
      put_len = put_col + 1'b1;
    end else begin
      put_len = len_base;
    end

    put_cursor = is_print ? put_col + 1'b1 : put_col;
  end

  // Read: map the screen row into the ring, top row is bottom plus one.
  always_comb begin
    row_sum      = {1'b0, row_mod[screen_row_i]} + {1'b0, bottom_q} + 1'b1;
    ring_row     = (row_sum >= (RW + 1)'(ROWS)) ? RW'(row_sum - (RW + 1)'(ROWS))
                                                : row_sum[RW-1:0];
    col_in_range = CMPW'(screen_col_i) < CMPW'(COLS);
    rd_col       = col_in_range ? screen_col_i : '0;
  end

  assign cell_waddr = AW'(put_row) * AW'(COLS) + AW'(put_col);
  assign cell_raddr = AW'(ring_row) * AW'(COLS) + AW'(rd_col);

  tcrr_cell_ram #(
    .DEPTH (DEPTH),
    .DW    (16)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (put_fire && is_print),
    .waddr_i (cell_waddr),
    .wdata_i ({text_color_q, char_code_i}),
    .re_i    (read_fire),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  tcrr_len_ram #(
    .ENTRIES (ROWS),
    .DW      (CW)
  ) u_len_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (put_fire),
    .waddr_i (put_row),
    .wdata_i (put_len),
    .re_i    (read_fire),
    .raddr_i (ring_row),
    .rdata_o (len_rdata)
  );

  // blank at or after the first zero cell, and beyond the last column
  assign hit = CMPW'(scol_q) < CMPW'(len_rdata);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcrr_pkg::ST_IDLE: begin
        if (read_fire) begin
          state_d = tcrr_pkg::ST_LOOKUP;
        end
      end
      tcrr_pkg::ST_LOOKUP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = tcrr_pkg::ST_IDLE;
        end
      end
      default: state_d = tcrr_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      tcrr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      tcrr_pkg::ST_LOOKUP: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    cursor_d = put_fire ? put_cursor : cursor_q;
    bottom_d = put_fire ? put_row : bottom_q;
    rowlen_d = put_fire ? put_len : rowlen_q;

    // hold while stalled, drop once taken
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    out_char_d  = out_char_q;
    out_color_d = out_color_q;
    if (out_load) begin
      out_char_d  = hit ? cell_rdata[7:0] : tcrr_pkg::CHAR_SPACE;
      out_color_d = hit ? cell_rdata[15:8] : tcrr_pkg::COLOR_BLANK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcrr_pkg::ST_IDLE;
      text_color_q <= tcrr_pkg::COLOR_RESET;
      cursor_q     <= '0;
      bottom_q     <= '0;
      rowlen_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      bottom_q    <= bottom_d;
      rowlen_q    <= rowlen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        text_color_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_fire) begin
      scol_q <= screen_col_i;
    end
    out_char_q  <= out_char_d;
    out_color_q <= out_color_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = out_char_q;
  assign cell_color_o = out_color_q;

endmodule

`default_nettype wire

[sv/tcrr_checker.sv]
// Port-level checks for the text console row ring, bound to the top level.
// Depends on tcrr_pkg and text_console_row_ring_defines.svh.
`default_nettype none

`include "text_console_row_ring_defines.svh"

module tcrr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       operation_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] cell_char_o,
  input wire logic [7:0] cell_color_o
);

  `TCRR_ASSERT(a_out_valid_holds, out_valid_o && out_stall_i |=> out_valid_o, "output word dropped while stalled")
  `TCRR_ASSERT(a_out_payload_holds, out_valid_o && out_stall_i |=> $stable(cell_char_o) && $stable(cell_color_o), "stalled output word changed")
  `TCRR_ASSERT(a_shown_char_nonzero, out_valid_o |-> cell_char_o != 8'h00, "zero character shown instead of blank")
  `TCRR_ASSERT(a_put_no_word, in_valid_i && !in_stall_o && operation_i == tcrr_pkg::OP_PUT && !out_valid_o |=> !out_valid_o, "put produced an output word")
  `TCRR_ASSERT(a_read_latency, in_valid_i && !in_stall_o && operation_i == tcrr_pkg::OP_READ && !out_valid_o |-> ##2 out_valid_o, "read word late")

endmodule

bind text_console_row_ring tcrr_checker u_tcrr_checker (.*);

`default_nettype wire

[bench/tcrr_console_checker.sv]
// Console checker: follows the colour register and both word channels of the
// text console row ring, predicts each read-out and compares it field by field.
// Depends on tcrr_pkg.
`default_nettype none

module tcrr_console_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic       operation_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [4:0] screen_row_i,
  input  wire logic [6:0] screen_col_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] cell_char_i,
  input  wire logic [7:0] cell_color_i,
  output int              errors_o,
  output int              pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] colour;
  } shown_cell_t;

  localparam shown_cell_t BLANK_CELL = {tcrr_pkg::CHAR_SPACE, tcrr_pkg::COLOR_BLANK};

  // Own copy of the screen: colour in the high byte, character in the low.
  logic [15:0] screen_cells [ROWS*COLS];
  int unsigned cursor_col;
  int unsigned bottom_row;
  logic [7:0]  text_colour;
  shown_cell_t shown_cells [$];

  task automatic report(input string line);
    $display("%s", line);
    errors_o++;
  endtask

  // Backspace, then scroll, then store and advance, then terminate.
  task automatic put_char(input logic [7:0] c);
    if (c == tcrr_pkg::CHAR_BS && cursor_col != 0) cursor_col--;
    if (c == tcrr_pkg::CHAR_NL || cursor_col == COLS) begin
      cursor_col = 0;
      bottom_row = (bottom_row + 1) % ROWS;
    end
    if (c != tcrr_pkg::CHAR_NL && c != tcrr_pkg::CHAR_BS) begin
      screen_cells[bottom_row*COLS + cursor_col] = {text_colour, c};
      cursor_col++;
    end
    if (cursor_col < COLS) screen_cells[bottom_row*COLS + cursor_col] = '0;
  endtask

  // Blank at or after the first zero character of the row, and beyond the last column.
  function automatic shown_cell_t shown_cell(input logic [4:0] row, input logic [6:0] col);
    int unsigned ring;
    logic [15:0] cell_word;
    ring = ((int'(row) % ROWS) + bottom_row + 1) % ROWS;
    if (col >= COLS) return BLANK_CELL;
    for (int j = 0; j <= int'(col); j++) begin
      cell_word = screen_cells[ring*COLS + j];
      if (cell_word[7:0] == tcrr_pkg::CHAR_NUL) return BLANK_CELL;
    end
    return {cell_word[7:0], cell_word[15:8]};
  endfunction

  task automatic check_cell();
    shown_cell_t want;
    if (shown_cells.size() == 0) begin
      report($sformatf("console: read-out %02h/%02h with no read waiting",
                       cell_char_i, cell_color_i));
    end else begin
      want = shown_cells.pop_front();
      if (cell_char_i !== want.ch)
        report($sformatf("console: cell_char %02h, want %02h", cell_char_i, want.ch));
      if (cell_color_i !== want.colour)
        report($sformatf("console: cell_color %02h, want %02h", cell_color_i, want.colour));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (screen_cells[k]) screen_cells[k] = '0;
      cursor_col  = 0;
      bottom_row  = 0;
      text_colour = tcrr_pkg::COLOR_RESET;
      shown_cells.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_cell();
      if (cfg_we_i) text_colour = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == tcrr_pkg::OP_READ)
          shown_cells.push_back(shown_cell(screen_row_i, screen_col_i));
        else put_char(char_code_i);
      end
    end
    pending_o = shown_cells.size();
  end

endmodule

`default_nettype wire

[bench/tb_text_console_row_ring.sv]
// Testbench top for the text console row ring: clock, reset, colour writes,
// put and read stimulus with random idling, and the verdict.
// Depends on tcrr_pkg, text_console_row_ring and tcrr_console_checker.
`default_nettype none

module tb_text_console_row_ring;

  localparam int ROWS          = 25;
  localparam int COLS          = 80;
  localparam int PHASES        = 5;
  localparam int PHASE_WORDS   = 400;
  // Longest correct stretch without a handshake is a sender gap plus a
  // receiver stall plus the read latency; this leaves a wide margin.
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [7:0] cfg_wdata  = 8'h00;
  logic       in_valid   = 1'b0;
  logic       operation  = tcrr_pkg::OP_PUT;
  logic [7:0] char_code  = tcrr_pkg::CHAR_NUL;
  logic [4:0] screen_row = '0;
  logic [6:0] screen_col = '0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] cell_char;
  logic [7:0] cell_color;

  int errors;
  int pending;
  int send_gap_pct  = 0;
  int out_stall_pct = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;
  int words_sent    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_row_ring #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .char_code_i  (char_code),
    .screen_row_i (screen_row),
    .screen_col_i (screen_col),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cell_char_o  (cell_char),
    .cell_color_o (cell_color)
  );

  tcrr_console_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_console_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .char_code_i  (char_code),
    .screen_row_i (screen_row),
    .screen_col_i (screen_col),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .cell_char_i  (cell_char),
    .cell_color_i (cell_color),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Receiver side: stall in bursts of random length; a rate of zero keeps
  // the output channel open every cycle.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word and hold it until it is taken. Stall is sampled at the
  // falling edge, so the rising edge that follows an open cycle is the one
  // that accepts the word. Optionally idle for a burst first.
  task automatic push_word(input logic op, input logic [7:0] ch,
                           input logic [4:0] row, input logic [6:0] col);
    logic stalled;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    char_code  <= ch;
    screen_row <= row;
    screen_col <= col;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled !== 1'b0);
    words_sent++;
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic put_char(input logic [7:0] c);
    push_word(tcrr_pkg::OP_PUT, c, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
    push_word(tcrr_pkg::OP_READ, 8'($urandom_range(0, 255)), row, col);
  endtask

  // Drop valid and wait until every read-out has come back, then give the
  // block a few cycles to finish a trailing put.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_colour(input logic [7:0] colour);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= colour;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random stretch of console traffic, mostly well-formed text.
  task automatic random_session();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // a line of text with the odd stray byte, maybe ended by a newline
        n = $urandom_range(1, 24);
        repeat (n) begin
          if ($urandom_range(0, 15) == 0) put_char(8'($urandom_range(0, 255)));
          else put_char(8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(0, 1) != 0) put_char(tcrr_pkg::CHAR_NL);
      end
      4: begin
        // fill a whole row so the cursor sits past the last column, then
        // backspace, wrap with a character, or end with a newline
        put_char(tcrr_pkg::CHAR_NL);
        repeat (COLS) put_char(8'($urandom_range(8'h21, 8'h7E)));
        case ($urandom_range(0, 2))
          0:       put_char(tcrr_pkg::CHAR_BS);
          1:       put_char(8'($urandom_range(8'h21, 8'h7E)));
          default: put_char(tcrr_pkg::CHAR_NL);
        endcase
        read_cell(5'(ROWS - 1), 7'(COLS - 1));
        read_cell(5'(ROWS - 2), 7'(COLS - 1));
        read_cell(5'(ROWS - 1), 7'd0);
      end
      5, 6, 7: begin
        // read-outs, weighted towards the written start of rows
        n = $urandom_range(1, 6);
        repeat (n) begin
          read_cell(5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(0, ROWS - 1)),
                    7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                       : ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, COLS - 1)));
        end
      end
      8: begin
        // rub out and retype
        n = $urandom_range(1, 6);
        repeat (n) put_char(tcrr_pkg::CHAR_BS);
        n = $urandom_range(0, 3);
        repeat (n) put_char(8'($urandom_range(8'h20, 8'h7E)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) put_char(8'($urandom_range(0, 255)));
      end
    endcase
    // now and then hold off until every read-out is home
    if ($urandom_range(0, 39) == 0) settle();
  endtask

  initial begin
    int         phase_end;
    logic [7:0] colour_plan [PHASES];
    int         gap_plan    [PHASES];
    int         stall_plan  [PHASES];

    colour_plan = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'h81};
    gap_plan    = '{25, 0, 50, 10, 0};
    stall_plan  = '{25, 0, 10, 50, 0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset colour.
    send_gap_pct  = 15;
    out_stall_pct = 15;
    read_cell(5'd0, 7'd0);                    // rows never written read blank
    read_cell(5'(ROWS - 1), 7'(COLS - 1));
    put_char(8'h48);
    put_char(8'hFF);                          // top character code
    put_char(tcrr_pkg::CHAR_NUL);             // zero is stored like any character
    put_char(8'h69);
    read_cell(5'(ROWS - 1), 7'd0);
    read_cell(5'(ROWS - 1), 7'd1);
    read_cell(5'(ROWS - 1), 7'd2);            // blanked from the stored zero on
    read_cell(5'(ROWS - 1), 7'd3);
    repeat (4) put_char(tcrr_pkg::CHAR_BS);
    put_char(tcrr_pkg::CHAR_BS);              // backspace at column zero
    read_cell(5'(ROWS - 1), 7'd0);
    put_char(tcrr_pkg::CHAR_NL);
    read_cell(5'd31, 7'd0);                   // row beyond the screen wraps
    read_cell(5'd0, 7'(COLS));                // column beyond the row blanks
    read_cell(5'd5, 7'd127);
    put_char(8'h01);
    read_cell(5'(ROWS - 1), 7'd0);
    read_cell(5'(ROWS - 2), 7'd0);

    // Random part: one colour and one idling mix per phase; the last phase
    // runs with both channels open.
    for (int p = 0; p < PHASES; p++) begin
      set_colour(colour_plan[p]);
      send_gap_pct  = gap_plan[p];
      out_stall_pct = stall_plan[p];
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) random_session();
    end

    // Drain, then allow for the read latency before the verdict.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/tcrr_pkg.sv
sv/tcrr_cell_ram.sv
sv/tcrr_len_ram.sv
sv/text_console_row_ring.sv
sv/tcrr_checker.sv
bench/tcrr_console_checker.sv
bench/tb_text_console_row_ring.sv
